>>> rtl/pfa_pkg.sv
// Shared types and constants for the page frame allocator.
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

   // Default pool size and fixed field widths.
   localparam int PAGES_DEF = 64;
   localparam int PAGE_W    = 8;

   // Operation codes carried in a request.
   typedef enum logic {
      FUNC_ALLOC   = 1'b0,
      FUNC_RELEASE = 1'b1
   } pfa_func_type;

   // Completion codes carried in a result.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_FREE  = 2'd1,
      STATUS_RANGE    = 2'd2,
      STATUS_NOT_USED = 2'd3
   } pfa_status_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOC_RD,
      ST_ALLOC_WR,
      ST_SEARCH,
      ST_SHIFT,
      ST_PUSH
   } pfa_state_type;

   // One request.
   typedef struct packed {
      pfa_func_type      func;
      logic [PAGE_W-1:0] page_number;
   } pfa_req_type;

   // One result.
   typedef struct packed {
      pfa_status_type    status;
      logic [PAGE_W-1:0] granted_page;
      logic [PAGE_W-1:0] pages_free;
   } pfa_rsp_type;

endpackage

`default_nettype wire

>>> rtl/pfa_ram.sv
// Single write port, single registered read port RAM for the used page list.
`timescale 1ns / 1ps
`default_nettype none

module pfa_ram
   import pfa_pkg::*;
#(
   parameter int  DEPTH  = PAGES_DEF,
   parameter int  DATA_W = PAGE_W,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port and registered read port; entries are undefined until written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/page_frame_allocator_top.sv
// Top level of the page frame allocator: request sequencer, free stack and result register.
`timescale 1ns / 1ps
`default_nettype none

// Page frame allocator.
// A request (allocate or release one page) is taken at a rising edge where start is
// high and busy is low. The block then stays busy while it works on that request and
// answers with exactly one result, shown on rsp_payload for one cycle with rsp_strobe.
// The receiver cannot stall; each result is taken in the cycle it is shown, and the
// next request may be taken in that same cycle.
// An allocate with no free page, or a release of a page out of range, is answered
// without going busy. An allocate reads the top of the free stack, then appends that
// page to the used list. A release that finds its page in the used list pushes it
// back onto the free stack once the gap is closed; otherwise it answers not used.
// A release searches the used list at one entry per cycle through its single read
// port, then closes the gap by moving each later entry down one place per cycle.
// The free stack and the used list are memories; the free stack keeps one valid bit
// per entry so that an entry never written reads as its own index.
// A synchronous reset returns the pool to all pages free, empties the used list and
// is ready for a request in the first cycle after reset; no clearing pass is needed.
module page_frame_allocator_top
   import pfa_pkg::*;
#(
   parameter int PAGES = PAGES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire pfa_req_type req_payload,
   output logic             rsp_strobe,
   output pfa_rsp_type      rsp_payload
);

   localparam int CW = $clog2(PAGES + 1);
   localparam int AW = $clog2(PAGES);

   pfa_state_type     state_ff, state_in;
   logic [CW-1:0]     free_cnt_ff, free_cnt_in;
   logic [CW-1:0]     used_cnt_ff, used_cnt_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic              chk_ff, chk_in;
   logic [AW-1:0]     wp_ff, wp_in;
   logic [PAGE_W-1:0] page_ff;
   logic              rsp_strobe_ff, rsp_strobe_in;
   pfa_rsp_type       rsp_ff, rsp_in;

   // Free stack storage.
   logic [PAGE_W-1:0] fs_mem [PAGES];
   logic [PAGES-1:0]  fs_vld_ff;
   logic [PAGE_W-1:0] fs_q_ff;
   logic              fs_re, fs_we;
   logic [AW-1:0]     fs_raddr, fs_waddr;

   // Used list port signals.
   logic              ul_we, ul_re;
   logic [AW-1:0]     ul_waddr, ul_raddr;
   logic [PAGE_W-1:0] ul_wdata, ul_rdata;

   logic              accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   pfa_ram #(
      .DEPTH  (PAGES),
      .DATA_W (PAGE_W)
   ) u_used_list (
      .clock   (clock),
      .wr_en   (ul_we),
      .wr_addr (ul_waddr),
      .wr_data (ul_wdata),
      .rd_en   (ul_re),
      .rd_addr (ul_raddr),
      .rd_data (ul_rdata)
   );

   // Sequencer: next state, counters, memory controls and result.
   always_comb begin
      state_in      = state_ff;
      free_cnt_in   = free_cnt_ff;
      used_cnt_in   = used_cnt_ff;
      scan_in       = scan_ff;
      chk_in        = chk_ff;
      wp_in         = wp_ff;
      fs_re         = 1'b0;
      fs_raddr      = '0;
      fs_we         = 1'b0;
      fs_waddr      = '0;
      ul_we         = 1'b0;
      ul_waddr      = '0;
      ul_wdata      = '0;
      ul_re         = 1'b0;
      ul_raddr      = '0;
      rsp_strobe_in = 1'b0;
      rsp_in.status       = STATUS_OK;
      rsp_in.granted_page = '0;
      rsp_in.pages_free   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_payload.func == FUNC_RELEASE) begin
                  if (req_payload.page_number >= PAGE_W'(PAGES)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.status = STATUS_RANGE;
                  end else begin
                     scan_in  = '0;
                     chk_in   = 1'b0;
                     state_in = ST_SEARCH;
                  end
               end else begin
                  if (free_cnt_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.status = STATUS_NO_FREE;
                  end else begin
                     state_in = ST_ALLOC_RD;
                  end
               end
            end
         end

         ST_ALLOC_RD: begin
            // Read the top of the free stack.
            fs_re    = 1'b1;
            fs_raddr = AW'(free_cnt_ff - CW'(1));
            state_in = ST_ALLOC_WR;
         end

         ST_ALLOC_WR: begin
            // Append the popped page to the used list.
            ul_we       = 1'b1;
            ul_waddr    = used_cnt_ff[AW-1:0];
            ul_wdata    = fs_q_ff;
            free_cnt_in = free_cnt_ff - CW'(1);
            used_cnt_in = used_cnt_ff + CW'(1);
            rsp_strobe_in       = 1'b1;
            rsp_in.status       = STATUS_OK;
            rsp_in.granted_page = fs_q_ff;
            state_in            = ST_IDLE;
         end

         ST_SEARCH: begin
            // Compare the entry read last cycle; while no match is found and entries remain, read the next one.
            if (chk_ff && (ul_rdata == page_ff)) begin
               wp_in    = AW'(scan_ff - CW'(1));
               chk_in   = 1'b0;
               state_in = ST_SHIFT;
            end else if (scan_ff == used_cnt_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_in.status = STATUS_NOT_USED;
               state_in      = ST_IDLE;
            end else begin
               ul_re    = 1'b1;
               ul_raddr = scan_ff[AW-1:0];
               scan_in  = scan_ff + CW'(1);
               chk_in   = 1'b1;
            end
         end

         ST_SHIFT: begin
            // Move each later entry down by one place.
            if (chk_ff) begin
               ul_we    = 1'b1;
               ul_waddr = wp_ff;
               ul_wdata = ul_rdata;
               wp_in    = wp_ff + AW'(1);
            end
            if (scan_ff < used_cnt_ff) begin
               ul_re    = 1'b1;
               ul_raddr = scan_ff[AW-1:0];
               scan_in  = scan_ff + CW'(1);
               chk_in   = 1'b1;
            end else begin
               chk_in   = 1'b0;
               state_in = ST_PUSH;
            end
         end

         ST_PUSH: begin
            // Return the page to the free stack.
            fs_we         = 1'b1;
            fs_waddr      = free_cnt_ff[AW-1:0];
            free_cnt_in   = free_cnt_ff + CW'(1);
            used_cnt_in   = used_cnt_ff - CW'(1);
            rsp_strobe_in = 1'b1;
            rsp_in.status = STATUS_OK;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.pages_free = PAGE_W'(free_cnt_in);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_cnt_ff   <= CW'(PAGES);
         used_cnt_ff   <= '0;
         scan_ff       <= '0;
         chk_ff        <= 1'b0;
         wp_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_cnt_ff   <= free_cnt_in;
         used_cnt_ff   <= used_cnt_in;
         scan_ff       <= scan_in;
         chk_ff        <= chk_in;
         wp_ff         <= wp_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Request page and result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff <= req_payload.page_number;
      end
      rsp_ff <= rsp_in;
   end

   // Free stack: an entry never written since reset reads as its own index.
   always_ff @(posedge clock) begin
      if (fs_we) begin
         fs_mem[fs_waddr] <= page_ff;
      end
      if (fs_re) begin
         fs_q_ff <= fs_vld_ff[fs_raddr] ? fs_mem[fs_raddr] : PAGE_W'(fs_raddr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fs_vld_ff <= '0;
      end else if (fs_we) begin
         fs_vld_ff[fs_waddr] <= 1'b1;
      end
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   // Every page is either free or in use.
   a_pool_conserved: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, free_cnt_ff} + {1'b0, used_cnt_ff}) == (CW + 1)'(PAGES))
      else $error("free and used counts do not add up to the pool size");

   // A taken request either starts work or answers at once.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_strobe))
      else $error("request taken without work or result");

   // A result is only shown once the sequencer has returned to idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still busy");

   // Only a successful allocate hands out a page number other than zero.
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_payload.granted_page != '0)) |-> (rsp_payload.status == STATUS_OK))
      else $error("page granted with an error status");

   // The release search never reads past the end of the used list.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (scan_ff <= used_cnt_ff))
      else $error("search ran past the used list");

endmodule

`default_nettype wire
